// ----- src/fcd_pkg.sv -----
// ----------------------------------------------------------------------------
// fcd_pkg: shared types and constants of the FAST corner detector
// Sizes, configuration codes, circle tables and small helper functions.
// ----------------------------------------------------------------------------
package fcd_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int XW          = $clog2(MAX_WIDTH);   // column counter
  localparam int YW          = $clog2(MAX_HEIGHT);  // row counter
  localparam int DW          = XW + 1;              // clamped width
  localparam int HW          = YW + 1;              // clamped height
  localparam int MIN_DIM     = 7;
  localparam int PIX_W       = 8;
  localparam int SCORE_W     = 8;
  localparam int ENTRY_W     = SCORE_W + 1;         // corner flag + score
  localparam int LINE_ROWS   = 6;
  localparam int WIN         = 7;
  localparam int RING_N      = 16;
  localparam int LANES       = 2 * RING_N;          // dark and bright sides
  localparam int COORD_W     = 11;
  localparam int DATA_W      = 32;
  localparam int PAD_W       = DATA_W - 2 * COORD_W - SCORE_W;
  localparam int QUEUE_DEPTH = 16;
  localparam int QAW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IW      = 3;
  localparam int CFG_DW      = 12;

  typedef enum logic [CFG_IW-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_SUPPRESS  = 3'd1,
    CFG_PATTERN   = 3'd2,
    CFG_WIDTH     = 3'd3,
    CFG_HEIGHT    = 3'd4
  } fcd_cfg_idx_e;

  typedef enum logic [1:0] {
    PAT_8  = 2'd0,
    PAT_12 = 2'd1,
    PAT_16 = 2'd2
  } fcd_pat_e;

  typedef struct packed {
    logic [SCORE_W-1:0] threshold;
    logic               suppress;
    logic [1:0]         pattern;
    logic [DW-1:0]      width;
    logic [HW-1:0]      height;
  } fcd_cfg_t;

  typedef struct packed {
    logic          vld;
    logic [XW-1:0] cx;
    logic [YW-1:0] cy;
  } fcd_pos_t;

  typedef struct packed {
    logic               vld;
    logic [XW-1:0]      cx;
    logic [YW-1:0]      cy;
    logic               flag;
    logic [SCORE_W-1:0] score;
  } fcd_cand_t;

  typedef struct packed {
    logic [XW-1:0]      x;
    logic [YW-1:0]      y;
    logic [SCORE_W-1:0] score;
  } fcd_result_t;

  // circle offsets (x, y); short rings padded with the centre
  localparam int R16_X [RING_N] = '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};
  localparam int R16_Y [RING_N] = '{3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1, 0, 1, 2, 3};
  localparam int R12_X [RING_N] = '{0, 1, 2, 2, 2, 1, 0, -1, -2, -2, -2, -1, 0, 0, 0, 0};
  localparam int R12_Y [RING_N] = '{2, 2, 1, 0, -1, -2, -2, -2, -1, 0, 1, 2, 0, 0, 0, 0};
  localparam int R8_X  [RING_N] = '{0, 1, 1, 1, 0, -1, -1, -1, 0, 0, 0, 0, 0, 0, 0, 0};
  localparam int R8_Y  [RING_N] = '{1, 1, 0, -1, -1, -1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0};

  function automatic int pat_points(logic [1:0] pat);
    int n;
    case (pat)
      PAT_8:   n = 8;
      PAT_12:  n = 12;
      default: n = 16;
    endcase
    return n;
  endfunction

  // lane of the same side, k places on round a ring of n points
  function automatic logic [4:0] lane_idx(int l, int k, int n);
    int i;
    int s;
    i = l % RING_N;
    s = i + k;
    if (s >= n) s = s - n;
    return {l >= RING_N, 4'(s)};
  endfunction

  function automatic logic [SCORE_W-1:0] min8(logic [SCORE_W-1:0] a, logic [SCORE_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [SCORE_W-1:0] max8(logic [SCORE_W-1:0] a, logic [SCORE_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ----- src/fcd_ram.sv -----
// ----------------------------------------------------------------------------
// fcd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/fcd_front.sv -----
// ----------------------------------------------------------------------------
// fcd_front: raster counters, line store, 7x7 window and corner test
// Seven-stage pipeline giving one corner flag and score per pixel.
// ----------------------------------------------------------------------------
module fcd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fcd_pkg::fcd_cfg_t     cfg_i,
  input  logic                  pix_vld_i,
  input  logic [7:0]            pix_i,
  output fcd_pkg::fcd_cand_t    cand_o
);
  import fcd_pkg::*;

  localparam int STAGES = 6;

  logic [XW-1:0] cx_q, cx_d, cx_use;
  logic [YW-1:0] cy_q, cy_d, cy_use;
  logic [HW-1:0] cy_tmp, cy_nx;
  logic [DW-1:0] cx_nx;

  // counters: wrap first if the size shrank, then step
  always_comb begin
    if ({1'b0, cx_q} >= cfg_i.width) begin
      cx_use = '0;
      cy_tmp = {1'b0, cy_q} + HW'(1);
    end else begin
      cx_use = cx_q;
      cy_tmp = {1'b0, cy_q};
    end
    cy_use = (cy_tmp >= cfg_i.height) ? '0 : cy_tmp[YW-1:0];
    cx_nx  = {1'b0, cx_use} + DW'(1);
    cy_nx  = {1'b0, cy_use} + HW'(1);
    cx_d   = cx_q;
    cy_d   = cy_q;
    if (pix_vld_i) begin
      if (cx_nx >= cfg_i.width) begin
        cx_d = '0;
        cy_d = (cy_nx >= cfg_i.height) ? '0 : cy_nx[YW-1:0];
      end else begin
        cx_d = cx_nx[XW-1:0];
        cy_d = cy_use;
      end
    end
  end

  fcd_pos_t pos_q [STAGES];
  logic [PIX_W-1:0] pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      for (int s = 0; s < STAGES; s++) pos_q[s] <= '0;
    end else begin
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      pos_q[0] <= '{vld: pix_vld_i, cx: cx_use, cy: cy_use};
      for (int s = 1; s < STAGES; s++) pos_q[s] <= pos_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_vld_i) pix_q <= pix_i;
  end

  // line store: one word per column, oldest row in the low byte
  logic [LINE_ROWS*PIX_W-1:0] line_rd;

  fcd_ram #(.WIDTH(LINE_ROWS * PIX_W), .DEPTH(MAX_WIDTH)) u_line (
    .clk_i   (clk_i),
    .we_i    (pos_q[0].vld),
    .waddr_i (pos_q[0].cx),
    .wdata_i ({pix_q, line_rd[LINE_ROWS*PIX_W-1:PIX_W]}),
    .re_i    (pix_vld_i),
    .raddr_i (cx_use),
    .rdata_o (line_rd)
  );

  logic [PIX_W-1:0] win_q [WIN][WIN];

  always_ff @(posedge clk_i) begin
    if (pos_q[0].vld) begin
      for (int r = 0; r < WIN; r++) begin
        for (int c = 0; c < WIN - 1; c++) win_q[r][c] <= win_q[r][c+1];
        win_q[r][WIN-1] <= (r < LINE_ROWS) ? line_rd[r*PIX_W +: PIX_W] : pix_q;
      end
    end
  end

  // stage: centre differences, dark lanes 0..15, bright lanes 16..31
  logic [SCORE_W-1:0] diff_d [LANES];
  logic [SCORE_W-1:0] pt;
  logic [SCORE_W-1:0] ctr;

  always_comb begin
    ctr = win_q[3][3];
    pt  = ctr;
    for (int i = 0; i < RING_N; i++) begin
      case (cfg_i.pattern)
        PAT_8:   pt = win_q[3 + R8_Y[i]][3 + R8_X[i]];
        PAT_12:  pt = win_q[3 + R12_Y[i]][3 + R12_X[i]];
        default: pt = win_q[3 + R16_Y[i]][3 + R16_X[i]];
      endcase
      diff_d[i]          = (ctr > pt) ? ctr - pt : '0;
      diff_d[i + RING_N] = (pt > ctr) ? pt - ctr : '0;
    end
  end

  logic [SCORE_W-1:0] v3_q [LANES];
  logic [SCORE_W-1:0] m2_d [LANES];
  logic [SCORE_W-1:0] m4_d [LANES];
  logic [SCORE_W-1:0] v4_q [LANES];
  logic [SCORE_W-1:0] m2_q [LANES];
  logic [SCORE_W-1:0] m4_q [LANES];
  logic [SCORE_W-1:0] arc_d [LANES];
  logic [SCORE_W-1:0] arc_q [LANES];
  logic [SCORE_W-1:0] m8;
  int                 npt;

  // stage: minima over runs of two and four
  always_comb begin
    npt = pat_points(cfg_i.pattern);
    for (int l = 0; l < LANES; l++) m2_d[l] = min8(v3_q[l], v3_q[lane_idx(l, 1, npt)]);
    for (int l = 0; l < LANES; l++) m4_d[l] = min8(m2_d[l], m2_d[lane_idx(l, 2, npt)]);
  end

  // stage: minimum over the whole arc (5, 7 or 9 points)
  always_comb begin
    m8 = '0;
    for (int l = 0; l < LANES; l++) begin
      case (cfg_i.pattern)
        PAT_8:  arc_d[l] = min8(m4_q[l], v4_q[lane_idx(l, 4, npt)]);
        PAT_12: arc_d[l] = min8(min8(m4_q[l], m2_q[lane_idx(l, 4, npt)]),
                                v4_q[lane_idx(l, 6, npt)]);
        default: begin
          m8       = min8(m4_q[l], m4_q[lane_idx(l, 4, npt)]);
          arc_d[l] = min8(m8, v4_q[lane_idx(l, 8, npt)]);
        end
      endcase
      if ((l % RING_N) >= npt) arc_d[l] = '0;
    end
  end

  // stage: max tree 32 -> 4, then 4 -> 1 and threshold test
  localparam int GROUPS = 4;
  localparam int GSIZE  = LANES / GROUPS;
  logic [SCORE_W-1:0] grp_d [GROUPS];
  logic [SCORE_W-1:0] grp_q [GROUPS];
  logic [SCORE_W-1:0] best;
  logic               evald;
  logic               is_corner;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GSIZE; k++) grp_d[g] = max8(grp_d[g], arc_q[g*GSIZE + k]);
    end
    best      = max8(max8(grp_q[0], grp_q[1]), max8(grp_q[2], grp_q[3]));
    evald     = (pos_q[5].cx >= XW'(WIN - 1)) && (pos_q[5].cy >= YW'(WIN - 1));
    is_corner = evald && (best > cfg_i.threshold);
  end

  always_ff @(posedge clk_i) begin
    v3_q  <= diff_d;
    v4_q  <= v3_q;
    m2_q  <= m2_d;
    m4_q  <= m4_d;
    arc_q <= arc_d;
    grp_q <= grp_d;
  end

  fcd_cand_t cand_q;

  // non-corners carry score zero so they never outrank a neighbour
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
    end else begin
      cand_q.vld   <= pos_q[5].vld;
      cand_q.cx    <= pos_q[5].cx;
      cand_q.cy    <= pos_q[5].cy;
      cand_q.flag  <= is_corner;
      cand_q.score <= is_corner ? best - SCORE_W'(1) : '0;
    end
  end

  assign cand_o = cand_q;

endmodule

// ----- src/fcd_nms.sv -----
// ----------------------------------------------------------------------------
// fcd_nms: score store, 3x3 score window and suppression decision
// Picks at most one kept corner per pixel, last column/row included.
// ----------------------------------------------------------------------------
module fcd_nms (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fcd_pkg::fcd_cfg_t     cfg_i,
  input  fcd_pkg::fcd_cand_t    cand_i,
  output logic                  push_o,
  output logic                  drop_o,
  output fcd_pkg::fcd_result_t  res_o
);
  import fcd_pkg::*;

  localparam int SWIN = 3;

  // two older score rows per column: low entry row y-2, high entry row y-1
  logic [2*ENTRY_W-1:0] srd;
  fcd_cand_t            n1_q, n2_q;
  logic [ENTRY_W-1:0]   sw_q [SWIN][SWIN];

  fcd_ram #(.WIDTH(2 * ENTRY_W), .DEPTH(MAX_WIDTH)) u_score (
    .clk_i   (clk_i),
    .we_i    (n1_q.vld && (n1_q.cx >= XW'(3))),
    .waddr_i (n1_q.cx - XW'(3)),
    .wdata_i ({n1_q.flag, n1_q.score, srd[2*ENTRY_W-1:ENTRY_W]}),
    .re_i    (cand_i.vld),
    .raddr_i (cand_i.cx - XW'(3)),
    .rdata_o (srd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1_q <= '0;
      n2_q <= '0;
    end else begin
      n1_q <= cand_i;
      n2_q <= n1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n1_q.vld) begin
      for (int r = 0; r < SWIN; r++) begin
        for (int c = 0; c < SWIN - 1; c++) sw_q[r][c] <= sw_q[r][c+1];
      end
      sw_q[0][SWIN-1] <= srd[ENTRY_W-1:0];
      sw_q[1][SWIN-1] <= srd[2*ENTRY_W-1:ENTRY_W];
      sw_q[2][SWIN-1] <= {n1_q.flag, n1_q.score};
    end
  end

  // window covers columns cx-5..cx-3 and rows cy-5..cy-3; index 3 is outside
  logic signed [XW+1:0] px, xmax;
  logic signed [YW+1:0] py, ymax;
  logic [SWIN-1:0]      ok_c, ok_r;
  logic [ENTRY_W-1:0]   ent [SWIN+1][SWIN+1];
  logic [1:0]           kept [2];
  logic                 last_col, last_row, hit;
  fcd_result_t          res;

  always_comb begin
    xmax = signed'({1'b0, cfg_i.width}) - (XW+2)'(4);
    ymax = signed'({1'b0, cfg_i.height}) - (YW+2)'(4);
    for (int j = 0; j < SWIN; j++) begin
      px      = signed'({2'b0, n2_q.cx}) - (XW+2)'(5 - j);
      ok_c[j] = (px >= (XW+2)'(3)) && (px <= xmax);
      py      = signed'({2'b0, n2_q.cy}) - (YW+2)'(5 - j);
      ok_r[j] = (py >= (YW+2)'(3)) && (py <= ymax);
    end
    for (int r = 0; r <= SWIN; r++) begin
      for (int c = 0; c <= SWIN; c++) begin
        ent[r][c] = '0;
        if (r < SWIN && c < SWIN && ok_r[r] && ok_c[c]) ent[r][c] = sw_q[r][c];
      end
    end
    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < 2; b++) begin
        kept[a][b] = ent[a+1][b+1][ENTRY_W-1];
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if ((dr != 0 || dc != 0) &&
                (ent[a+1+dr][b+1+dc][SCORE_W-1:0] >= ent[a+1][b+1][SCORE_W-1:0]))
              kept[a][b] = 1'b0;
          end
        end
      end
    end
    last_col = ({1'b0, n2_q.cx} == cfg_i.width - DW'(1));
    last_row = ({1'b0, n2_q.cy} == cfg_i.height - HW'(1));

    hit       = 1'b0;
    res.x     = n2_q.cx - XW'(3);
    res.y     = n2_q.cy - YW'(3);
    res.score = '0;
    if (!cfg_i.suppress) begin
      hit = n2_q.flag;
    end else begin
      // raster priority among the candidates decided at this pixel
      for (int a = 1; a >= 0; a--) begin
        for (int b = 1; b >= 0; b--) begin
          if (kept[a][b] && (a == 0 || last_row) && (b == 0 || last_col)) begin
            hit       = 1'b1;
            res.x     = n2_q.cx - XW'(4 - b);
            res.y     = n2_q.cy - YW'(4 - a);
            res.score = ent[a+1][b+1][SCORE_W-1:0];
          end
        end
      end
    end
  end

  assign push_o = n2_q.vld && hit;
  assign drop_o = n2_q.vld && !hit;
  assign res_o  = res;

endmodule

// ----- src/fcd_queue.sv -----
// ----------------------------------------------------------------------------
// fcd_queue: result queue between decision logic and output port
// Small register FIFO; the caller guarantees it never overflows.
// ----------------------------------------------------------------------------
module fcd_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  fcd_pkg::fcd_result_t  data_i,
  input  logic                  pop_i,
  output logic                  valid_o,
  output fcd_pkg::fcd_result_t  data_o
);
  import fcd_pkg::*;

  fcd_result_t    mem_q [QUEUE_DEPTH];
  logic [QAW-1:0] wptr_q, rptr_q;
  logic [QCW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + QAW'(1);
      if (pop_i)  rptr_q <= rptr_q + QAW'(1);
      cnt_q <= cnt_q + QCW'(push_i) - QCW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];

endmodule

// ----- src/fast_corner_detector_nms_core.sv -----
// ----------------------------------------------------------------------------
// fast_corner_detector_nms_core: streaming FAST corner detector with NMS
// Raster pixels in, corner (x, y, score) words out.
// ----------------------------------------------------------------------------
// One pixel word is taken per clock while the input is not stalled; a pixel's
// result word passes the front pipeline and the n1_q and n2_q registers before
// it enters the output queue. The input only stalls when sixteen words are
// outstanding (in the pipeline or waiting in the output queue), so the rate is
// set by how fast the sink drains results. No clearing pass is needed at start
// of frame: score entries outside the current frame's interior are masked by position.
// ----------------------------------------------------------------------------
module fast_corner_detector_nms_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] pixel
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [fcd_pkg::DATA_W-1:0]    m_axis_tdata,   // corner_x, corner_y, corner_score
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fcd_pkg::CFG_IW-1:0]    cfg_index_i,
  input  logic [fcd_pkg::CFG_DW-1:0]    cfg_data_i
);
  import fcd_pkg::*;

  fcd_cfg_t cfg_q, cfg_d;

  // registers hold clamped sizes; pattern code three behaves as 9 of 16
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD: cfg_d.threshold = cfg_data_i[SCORE_W-1:0];
        CFG_SUPPRESS:  cfg_d.suppress  = cfg_data_i[0];
        CFG_PATTERN:   cfg_d.pattern   = cfg_data_i[1:0];
        CFG_WIDTH: begin
          if (int'(cfg_data_i) < MIN_DIM)        cfg_d.width = DW'(MIN_DIM);
          else if (int'(cfg_data_i) > MAX_WIDTH) cfg_d.width = DW'(MAX_WIDTH);
          else                                   cfg_d.width = DW'(cfg_data_i);
        end
        CFG_HEIGHT: begin
          if (int'(cfg_data_i) < MIN_DIM)         cfg_d.height = HW'(MIN_DIM);
          else if (int'(cfg_data_i) > MAX_HEIGHT) cfg_d.height = HW'(MAX_HEIGHT);
          else                                    cfg_d.height = HW'(cfg_data_i);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= SCORE_W'(10);
      cfg_q.suppress  <= 1'b1;
      cfg_q.pattern   <= PAT_16;
      cfg_q.width     <= DW'(640);
      cfg_q.height    <= HW'(480);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  // credit: every accepted pixel holds one slot until dropped or popped
  logic           in_acc, out_acc, push, drop;
  logic [QCW-1:0] outst_q, outst_d;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (outst_q < QCW'(QUEUE_DEPTH));
  assign outst_d       = outst_q + QCW'(in_acc) - QCW'(drop) - QCW'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) outst_q <= '0;
    else         outst_q <= outst_d;
  end

  fcd_cand_t   cand;
  fcd_result_t res, head;

  fcd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .pix_vld_i (in_acc),
    .pix_i     (s_axis_tdata),
    .cand_o    (cand)
  );

  fcd_nms u_nms (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .cand_i (cand),
    .push_o (push),
    .drop_o (drop),
    .res_o  (res)
  );

  fcd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .pop_i   (out_acc),
    .valid_o (m_axis_tvalid),
    .data_o  (head)
  );

  // [10:0] corner_x, [21:11] corner_y, [29:22] corner_score, rest zero
  assign m_axis_tdata = {PAD_W'(0), head.score, COORD_W'(head.y), COORD_W'(head.x)};

endmodule

// ----- src/fcd_checker.sv -----
// ----------------------------------------------------------------------------
// fcd_checker: port-level checks for the corner detector
// Bound to the top level; watches ports only.
// ----------------------------------------------------------------------------
module fcd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [7:0]                    s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [fcd_pkg::DATA_W-1:0]    m_axis_tdata,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [fcd_pkg::CFG_IW-1:0]    cfg_index_i,
  input logic [fcd_pkg::CFG_DW-1:0]    cfg_data_i
);
  import fcd_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // nothing comes out straight after reset
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result word present after reset");

  // corners lie three or more pixels in from the top left
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[10:0] >= 11'd3) && (m_axis_tdata[21:11] >= 11'd3))
    else $error("corner outside interior");

endmodule

bind fast_corner_detector_nms_core fcd_checker u_fcd_checker (.*);
